>>> hw/rtl/line_segment_rasterizer_unit_defines.svh
// Assertion macros for the line segment rasterizer unit.
// Included by the modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef LINE_SEGMENT_RASTERIZER_UNIT_DEFINES_SVH
`define LINE_SEGMENT_RASTERIZER_UNIT_DEFINES_SVH

// Check a same-cycle implication outside reset
`define LSR_CHECK_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a next-cycle implication outside reset
`define LSR_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/lsr_pkg.sv
// Shared types and constants for the line segment rasterizer unit.
// No dependencies; used by lsr_ctrl, lsr_dpath and the top level.
package lsr_pkg;

    // Operation codes of an input word
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_SCREEN_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_SCREEN_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_ROW_PITCH       = 2'd2;
    localparam logic [1:0] CFG_BYTES_PER_PIXEL = 2'd3;

    // Configuration reset values
    localparam logic [14:0] RST_SCREEN_WIDTH    = 15'd640;
    localparam logic [14:0] RST_SCREEN_HEIGHT   = 15'd480;
    localparam logic [15:0] RST_ROW_PITCH       = 16'd2560;
    localparam logic [2:0]  RST_BYTES_PER_PIXEL = 3'd4;

    // Span width and divider step count (one quotient bit per step)
    localparam int SPAN_W    = 17;
    localparam int DIV_STEPS = SPAN_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef struct packed {
        logic               operation;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic [15:0]        end_x;
        logic [15:0]        end_y;
        logic [31:0]        pixel_value;
    } in_word_t;

    typedef struct packed {
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
        logic [31:0] byte_offset;
        logic        write_enable;
        logic [31:0] colour_out;
        logic        last_pixel;
    } out_word_t;

    typedef struct packed {
        logic [14:0] screen_width;
        logic [14:0] screen_height;
        logic [15:0] row_pitch;
        logic [2:0]  bytes_per_pixel;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic coord;
        logic scale;
        logic write;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic seg_active;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

>>> hw/rtl/lsr_ctrl.sv
// Sequencer for the line segment rasterizer: accepts words and steps the datapath.
// Depends on lsr_pkg and line_segment_rasterizer_unit_defines.svh.
`include "line_segment_rasterizer_unit_defines.svh"

module lsr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_op,
    output logic              in_ready,
    input  lsr_pkg::status_t  sts,
    output lsr_pkg::cmd_t     cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_DIV   = 6'b000100,
        S_COORD = 6'b001000,
        S_SCALE = 6'b010000,
        S_WRITE = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // Sequence one word
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_op == lsr_pkg::OP_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else if (sts.seg_active)
                    begin
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_COORD;
                end
            end
            S_COORD:
            begin
                cmd.coord  = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                // Hold until the output register can take the word
                if (sts.out_free)
                begin
                    cmd.write  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `LSR_CHECK_NEXT(a_div_exit, (state_reg == S_DIV) && sts.div_last, state_reg == S_COORD, "divider did not hand over to coordinate stage")
    `LSR_CHECK_NEXT(a_idle_step, accept && (in_op == lsr_pkg::OP_STEP) && !sts.seg_active, state_reg == S_WRITE, "idle step did not go straight to write")
    `LSR_CHECK_NEXT(a_write_hold, (state_reg == S_WRITE) && !sts.out_free, state_reg == S_WRITE, "left write state while output was blocked")

endmodule

>>> hw/rtl/lsr_dpath.sv
// Datapath of the line segment rasterizer: segment state, multiplier, serial divider,
// coordinate and offset stages, output register. Depends on lsr_pkg and the defines header.
`include "line_segment_rasterizer_unit_defines.svh"

module lsr_dpath #(
    parameter int COORD_WIDTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lsr_pkg::in_word_t  in_word,
    input  lsr_pkg::cfg_t      cfg,
    input  lsr_pkg::cmd_t      cmd,
    output lsr_pkg::status_t   sts,
    output logic               out_valid,
    input  logic               out_ready,
    output lsr_pkg::out_word_t out_word
);

    localparam int CW = COORD_WIDTH;
    localparam int SW = lsr_pkg::SPAN_W;

    // Segment state
    logic          active_reg;
    logic [SW-1:0] index_reg;
    logic [SW-1:0] total_reg;
    logic [CW-1:0] origin_x_reg;
    logic [CW-1:0] origin_y_reg;
    logic [SW-1:0] minor_mag_reg;
    logic          minor_neg_reg;
    logic          axis_y_reg;
    logic          dir_neg_reg;
    logic [31:0]   colour_reg;

    // Divider state
    logic [SW-1:0]               rem_reg;
    logic [SW-1:0]               lo_reg;
    logic [SW-1:0]               quot_reg;
    logic [lsr_pkg::CNT_W-1:0]   cnt_reg;

    // Coordinate and offset stages
    logic [CW-1:0] ux_reg;
    logic [CW-1:0] uy_reg;
    logic [31:0]   prod_y_reg;
    logic [18:0]   prod_x_reg;
    logic          on_screen_reg;

    // Output register
    logic               out_valid_reg;
    lsr_pkg::out_word_t out_word_reg;

    // Load decode
    logic signed [SW:0] dx;
    logic signed [SW:0] dy;
    logic [SW-1:0]      adx;
    logic [SW-1:0]      ady;
    logic               major_y;

    assign dx  = $signed({2'b00, in_word.end_x})
               - $signed({{2{in_word.start_x[15]}}, in_word.start_x});
    assign dy  = $signed({2'b00, in_word.end_y})
               - $signed({{2{in_word.start_y[15]}}, in_word.start_y});
    assign adx = dx[SW] ? SW'(-dx) : dx[SW-1:0];
    assign ady = dy[SW] ? SW'(-dy) : dy[SW-1:0];
    assign major_y = (ady > adx);

    // Minor magnitude times index
    logic [2*SW-1:0] prod;
    assign prod = {{SW{1'b0}}, minor_mag_reg} * {{SW{1'b0}}, index_reg};

    // Restoring divide step
    logic [SW:0]   trial;
    logic          ge;
    logic [SW-1:0] rem_next;
    assign trial    = {rem_reg, lo_reg[SW-1]};
    assign ge       = (trial >= {1'b0, total_reg});
    assign rem_next = ge ? SW'(trial - {1'b0, total_reg}) : trial[SW-1:0];

    // Coordinates, wrapped to the coordinate width
    logic [CW-1:0] off_cw;
    logic [CW-1:0] minor_cw;
    logic [CW-1:0] idx_cw;
    logic [CW-1:0] major_org;
    logic [CW-1:0] minor_org;
    logic [CW-1:0] major_cw;
    logic [CW-1:0] minor_c;

    assign off_cw    = (total_reg == '0) ? '0 : quot_reg[CW-1:0];
    assign minor_cw  = minor_neg_reg ? ({CW{1'b0}} - off_cw) : off_cw;
    assign idx_cw    = index_reg[CW-1:0];
    assign major_org = axis_y_reg ? origin_y_reg : origin_x_reg;
    assign minor_org = axis_y_reg ? origin_x_reg : origin_y_reg;
    assign major_cw  = dir_neg_reg ? (major_org - idx_cw) : (major_org + idx_cw);
    assign minor_c   = minor_org + minor_cw;

    logic [15:0] ux16;
    logic [15:0] uy16;
    assign ux16 = 16'(ux_reg);
    assign uy16 = 16'(uy_reg);

    logic last;
    assign last = (index_reg >= total_reg);

    // Latch a segment, step the index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            index_reg  <= '0;
            total_reg  <= '0;
        end
        else if (cmd.load)
        begin
            active_reg <= 1'b1;
            index_reg  <= '0;
            total_reg  <= major_y ? ady : adx;
        end
        else if (cmd.write && active_reg)
        begin
            if (last)
            begin
                active_reg <= 1'b0;
            end
            else
            begin
                index_reg <= index_reg + 1'b1;
            end
        end
    end

    // Hold segment geometry and colour
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            origin_x_reg  <= in_word.start_x[CW-1:0];
            origin_y_reg  <= in_word.start_y[CW-1:0];
            axis_y_reg    <= major_y;
            colour_reg    <= in_word.pixel_value;
            if (major_y)
            begin
                minor_mag_reg <= adx;
                minor_neg_reg <= dx[SW];
                dir_neg_reg   <= dy[SW];
            end
            else
            begin
                minor_mag_reg <= ady;
                minor_neg_reg <= dy[SW];
                dir_neg_reg   <= dx[SW];
            end
        end
    end

    // Multiply, then one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.mul)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            rem_reg  <= prod[2*SW-1:SW];
            lo_reg   <= prod[SW-1:0];
            quot_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_next;
            lo_reg   <= {lo_reg[SW-2:0], 1'b0};
            quot_reg <= {quot_reg[SW-2:0], ge};
        end
    end

    assign sts.div_last = (cnt_reg == lsr_pkg::CNT_W'(lsr_pkg::DIV_STEPS - 1));

    // Place the pixel, then scale for the offset
    always_ff @(posedge clk)
    begin
        if (cmd.coord)
        begin
            ux_reg <= axis_y_reg ? minor_c : major_cw;
            uy_reg <= axis_y_reg ? major_cw : minor_c;
        end
        if (cmd.scale)
        begin
            prod_y_reg    <= {16'd0, uy16} * {16'd0, cfg.row_pitch};
            prod_x_reg    <= {3'd0, ux16} * {16'd0, cfg.bytes_per_pixel};
            on_screen_reg <= (ux16 < {1'b0, cfg.screen_width}) &&
                             (uy16 < {1'b0, cfg.screen_height});
        end
    end

    // Output register: load on write, drop on take
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.write)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            if (active_reg)
            begin
                out_word_reg.pixel_x      <= ux16;
                out_word_reg.pixel_y      <= uy16;
                out_word_reg.byte_offset  <= prod_y_reg + 32'(prod_x_reg);
                out_word_reg.write_enable <= on_screen_reg;
                out_word_reg.colour_out   <= colour_reg;
                out_word_reg.last_pixel   <= last;
            end
            else
            begin
                out_word_reg            <= '0;
                out_word_reg.last_pixel <= 1'b1;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_word       = out_word_reg;
    assign sts.seg_active = active_reg;
    assign sts.out_free   = !out_valid_reg || out_ready;

    `LSR_CHECK_IMP(a_index_bound, active_reg, index_reg <= total_reg,
                   "step index ran past the span")
    `LSR_CHECK_IMP(a_quot_bound, cmd.coord && (total_reg != '0), quot_reg <= minor_mag_reg,
                   "minor offset exceeds minor delta")
    `LSR_CHECK_NEXT(a_last_ends, cmd.write && active_reg && (index_reg >= total_reg),
                    !active_reg, "segment stayed active after its last pixel")

endmodule

>>> hw/rtl/line_segment_rasterizer_unit.sv
// Top level of the line segment rasterizer: configuration registers, sequencer, datapath.
// Depends on lsr_pkg, lsr_ctrl and lsr_dpath.
//
// Usage:
//   in_valid/in_ready carry input words. A load word (operation 0) latches both
//   endpoints and the colour and yields no output; a step word (operation 1)
//   yields one pixel word on out_valid/out_ready.
//   Sequence: a load is handled in the idle state. A step on an active segment
//   passes the multiply, the divider (one quotient bit per step, the step count
//   set by the 17-bit span), the coordinate, the offset scale and the write
//   state before it reaches the output register; the next word is accepted once
//   the write is done. A step with no active segment goes straight from idle to
//   the write state. A new word is accepted while a finished pixel still sits in
//   the output register; a step then waits in its write cycle until the receiver
//   takes it. Configuration is written through cfg_we/cfg_index/cfg_data; the
//   user must write it only while idle, as the block does not enforce this.
//   Reset loads a 640x480 screen, 2560-byte pitch, 4 bytes per pixel, and
//   leaves no segment active with the output register empty.

module line_segment_rasterizer_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lsr_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output lsr_pkg::out_word_t out_word,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    lsr_pkg::cfg_t    cfg_reg;
    lsr_pkg::cmd_t    cmd;
    lsr_pkg::status_t sts;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width    <= lsr_pkg::RST_SCREEN_WIDTH;
            cfg_reg.screen_height   <= lsr_pkg::RST_SCREEN_HEIGHT;
            cfg_reg.row_pitch       <= lsr_pkg::RST_ROW_PITCH;
            cfg_reg.bytes_per_pixel <= lsr_pkg::RST_BYTES_PER_PIXEL;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lsr_pkg::CFG_SCREEN_WIDTH:    cfg_reg.screen_width    <= cfg_data[14:0];
                lsr_pkg::CFG_SCREEN_HEIGHT:   cfg_reg.screen_height   <= cfg_data[14:0];
                lsr_pkg::CFG_ROW_PITCH:       cfg_reg.row_pitch       <= cfg_data;
                lsr_pkg::CFG_BYTES_PER_PIXEL: cfg_reg.bytes_per_pixel <= cfg_data[2:0];
                default:
                begin
                end
            endcase
        end
    end

    lsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_op    (in_word.operation),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lsr_dpath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule
